// ===== design/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg: shared types and constants for the LRU page replacement block
// Port word layouts, controller state encoding and the control groups that
// run between the controller and the chain of frame cells.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  // Fixed field widths of the port words
  localparam int PAGE_W = 20;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 5'd4;

  // Input word: one page access
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last_access;
  } lrupr_in_t;

  // Result word
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [CNT_W-1:0]  hits_so_far;
    logic [CNT_W-1:0]  faults_so_far;
  } lrupr_out_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } lrupr_state_t;

  // Search flags carried cell to cell by the scan wave
  typedef struct packed {
    logic hit;
    logic empty;
  } lrupr_wave_flags_t;

  // Update command broadcast to all cells
  typedef struct packed {
    logic apply;    // update cycle
    logic is_hit;   // access hit: no page write
    logic age_all;  // age active valid frames, else only those younger than limit
    logic clear;    // end of run: drop all frames and ranks
  } lrupr_upd_t;

endpackage

// ===== design/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement: LRU page frame set with hit and fault counting
// A row of frame cells searched by a wave that moves one cell per cycle,
// followed by a single-cycle broadcast update of pages, valid bits and ranks.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+------------------------------
//   access   | start, busy, in_data           | taken when start && !busy
//   result   | out_valid, out_data            | one-cycle strobe, no stall
//   config   | cfg_valid, cfg_ready, cfg_data | written when valid && ready
//
// Busy rises at the accepting edge and stays high through the scan and apply
// states; the result strobe comes in the first cycle busy is low, so a new
// access can be accepted in the same cycle as the result strobe.
// The search wave sets the scan length; it crosses one frame cell per cycle.
// Synchronous active-low reset empties all frames, zeroes both counts and sets
// the frame count to 4. The result side cannot stall; the access side only
// waits on busy. cfg_ready is always high.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  lrupr_pkg::lrupr_in_t         in_data,
  output logic                         out_valid,
  output lrupr_pkg::lrupr_out_t        out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]  cfg_data
);
  import lrupr_pkg::*;

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int N_W   = $clog2(NUM_FRAMES + 1);

  logic [PAGE_BITS-1:0] page;
  logic [N_W-1:0]       n_active;
  lrupr_upd_t           upd;
  logic [IDX_W-1:0]     slot;
  logic [IDX_W-1:0]     limit;

  // Wave stage outputs of each cell
  lrupr_wave_flags_t    w_flags     [NUM_FRAMES];
  logic [IDX_W-1:0]     w_hit_idx   [NUM_FRAMES];
  logic [IDX_W-1:0]     w_hit_rank  [NUM_FRAMES];
  logic [IDX_W-1:0]     w_empty_idx [NUM_FRAMES];
  logic [IDX_W-1:0]     w_best_rank [NUM_FRAMES];
  logic [IDX_W-1:0]     w_best_idx  [NUM_FRAMES];
  logic [PAGE_BITS-1:0] w_best_page [NUM_FRAMES];

  lrupr_ctrl #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .page_o      (page),
    .n_o         (n_active),
    .upd_o       (upd),
    .slot_o      (slot),
    .limit_o     (limit),
    .flags_i     (w_flags[NUM_FRAMES-1]),
    .hit_idx_i   (w_hit_idx[NUM_FRAMES-1]),
    .hit_rank_i  (w_hit_rank[NUM_FRAMES-1]),
    .empty_idx_i (w_empty_idx[NUM_FRAMES-1]),
    .best_idx_i  (w_best_idx[NUM_FRAMES-1]),
    .best_page_i (w_best_page[NUM_FRAMES-1])
  );

  // Frame cell chain; cell 0 starts from an empty wave
  for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
    lrupr_wave_flags_t    in_flags;
    logic [IDX_W-1:0]     in_hit_idx, in_hit_rank, in_empty_idx;
    logic [IDX_W-1:0]     in_best_rank, in_best_idx;
    logic [PAGE_BITS-1:0] in_best_page;

    if (k == 0) begin : g_seed
      assign in_flags     = '0;
      assign in_hit_idx   = '0;
      assign in_hit_rank  = '0;
      assign in_empty_idx = '0;
      assign in_best_rank = '0;
      assign in_best_idx  = '0;
      assign in_best_page = '0;
    end else begin : g_link
      assign in_flags     = w_flags[k-1];
      assign in_hit_idx   = w_hit_idx[k-1];
      assign in_hit_rank  = w_hit_rank[k-1];
      assign in_empty_idx = w_empty_idx[k-1];
      assign in_best_rank = w_best_rank[k-1];
      assign in_best_idx  = w_best_idx[k-1];
      assign in_best_page = w_best_page[k-1];
    end

    lrupr_cell #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .CELL_IDX   (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .page_i      (page),
      .n_i         (n_active),
      .flags_i     (in_flags),
      .hit_idx_i   (in_hit_idx),
      .hit_rank_i  (in_hit_rank),
      .empty_idx_i (in_empty_idx),
      .best_rank_i (in_best_rank),
      .best_idx_i  (in_best_idx),
      .best_page_i (in_best_page),
      .flags_o     (w_flags[k]),
      .hit_idx_o   (w_hit_idx[k]),
      .hit_rank_o  (w_hit_rank[k]),
      .empty_idx_o (w_empty_idx[k]),
      .best_rank_o (w_best_rank[k]),
      .best_idx_o  (w_best_idx[k]),
      .best_page_o (w_best_page[k]),
      .upd_i       (upd),
      .slot_i      (slot),
      .limit_i     (limit)
    );
  end

endmodule

// ===== design/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// lrupr_cell: one page frame of the fully associative set
// Holds page, valid bit and recency rank. Merges its own match, empty and
// victim candidates into the scan wave and registers it for the next cell.
// Applies the broadcast update to its page, valid bit and rank registers.
// ----------------------------------------------------------------------------
module lrupr_cell #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 20,
  parameter int CELL_IDX   = 0,
  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
  localparam int N_W   = $clog2(NUM_FRAMES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [PAGE_BITS-1:0]          page_i,
  input  logic [N_W-1:0]                n_i,
  // incoming wave
  input  lrupr_pkg::lrupr_wave_flags_t  flags_i,
  input  logic [IDX_W-1:0]              hit_idx_i,
  input  logic [IDX_W-1:0]              hit_rank_i,
  input  logic [IDX_W-1:0]              empty_idx_i,
  input  logic [IDX_W-1:0]              best_rank_i,
  input  logic [IDX_W-1:0]              best_idx_i,
  input  logic [PAGE_BITS-1:0]          best_page_i,
  // outgoing wave, registered
  output lrupr_pkg::lrupr_wave_flags_t  flags_o,
  output logic [IDX_W-1:0]              hit_idx_o,
  output logic [IDX_W-1:0]              hit_rank_o,
  output logic [IDX_W-1:0]              empty_idx_o,
  output logic [IDX_W-1:0]              best_rank_o,
  output logic [IDX_W-1:0]              best_idx_o,
  output logic [PAGE_BITS-1:0]          best_page_o,
  // update
  input  lrupr_pkg::lrupr_upd_t         upd_i,
  input  logic [IDX_W-1:0]              slot_i,
  input  logic [IDX_W-1:0]              limit_i
);
  import lrupr_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(NUM_FRAMES - 1);

  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 valid_r, valid_nxt;
  logic [IDX_W-1:0]     rank_r, rank_nxt;

  lrupr_wave_flags_t    flags_r, flags_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]     hit_rank_r, hit_rank_nxt;
  logic [IDX_W-1:0]     empty_idx_r, empty_idx_nxt;
  logic [IDX_W-1:0]     best_rank_r, best_rank_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [PAGE_BITS-1:0] best_page_r, best_page_nxt;

  logic active;

  assign active = (N_W'(CELL_IDX) < n_i);

  // Scan: lowest matching frame, lowest empty frame, oldest frame
  always_comb begin
    flags_nxt     = flags_i;
    hit_idx_nxt   = hit_idx_i;
    hit_rank_nxt  = hit_rank_i;
    empty_idx_nxt = empty_idx_i;
    best_rank_nxt = best_rank_i;
    best_idx_nxt  = best_idx_i;
    best_page_nxt = best_page_i;
    if (!flags_i.hit && active && valid_r && (page_r == page_i)) begin
      flags_nxt.hit = 1'b1;
      hit_idx_nxt   = MY_IDX;
      hit_rank_nxt  = rank_r;
    end
    if (!flags_i.empty && active && !valid_r) begin
      flags_nxt.empty = 1'b1;
      empty_idx_nxt   = MY_IDX;
    end
    // frame 0 seeds the victim; later frames win only on a strictly older rank
    if ((CELL_IDX == 0) || (active && (rank_r > best_rank_i))) begin
      best_rank_nxt = rank_r;
      best_idx_nxt  = MY_IDX;
      best_page_nxt = page_r;
    end
  end

  // Frame update
  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (upd_i.apply) begin
      if (upd_i.clear) begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end else if (slot_i == MY_IDX) begin
        rank_nxt = '0;
        if (!upd_i.is_hit) begin
          page_nxt  = page_i;
          valid_nxt = 1'b1;
        end
      end else if (active && valid_r && (upd_i.age_all || (rank_r < limit_i))
                   && (rank_r != RANK_MAX)) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  // Page store and wave stage: no reset needed
  always_ff @(posedge clk) begin
    page_r      <= page_nxt;
    flags_r     <= flags_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    empty_idx_r <= empty_idx_nxt;
    best_rank_r <= best_rank_nxt;
    best_idx_r  <= best_idx_nxt;
    best_page_r <= best_page_nxt;
  end

  assign flags_o     = flags_r;
  assign hit_idx_o   = hit_idx_r;
  assign hit_rank_o  = hit_rank_r;
  assign empty_idx_o = empty_idx_r;
  assign best_rank_o = best_rank_r;
  assign best_idx_o  = best_idx_r;
  assign best_page_o = best_page_r;

endmodule

// ===== design/lrupr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrupr_ctrl: access sequencer, counters and result register
// Latches the access, times the scan wave through the cell chain, picks the
// slot from the final wave, drives the update and registers the result word.
// ----------------------------------------------------------------------------
module lrupr_ctrl #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 20,
  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
  localparam int N_W   = $clog2(NUM_FRAMES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // access channel
  input  logic                          start,
  output logic                          busy,
  input  lrupr_pkg::lrupr_in_t          in_data,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]   cfg_data,
  // result
  output logic                          out_valid,
  output lrupr_pkg::lrupr_out_t         out_data,
  // to cells
  output logic [PAGE_BITS-1:0]          page_o,
  output logic [N_W-1:0]                n_o,
  output lrupr_pkg::lrupr_upd_t         upd_o,
  output logic [IDX_W-1:0]              slot_o,
  output logic [IDX_W-1:0]              limit_o,
  // final wave from the last cell
  input  lrupr_pkg::lrupr_wave_flags_t  flags_i,
  input  logic [IDX_W-1:0]              hit_idx_i,
  input  logic [IDX_W-1:0]              hit_rank_i,
  input  logic [IDX_W-1:0]              empty_idx_i,
  input  logic [IDX_W-1:0]              best_idx_i,
  input  logic [PAGE_BITS-1:0]          best_page_i
);
  import lrupr_pkg::*;

  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(NUM_FRAMES - 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  lrupr_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [CFG_W-1:0]      cfg_frames_r, cfg_frames_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic                  last_r, last_nxt;
  logic [N_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]      hits_r, hits_nxt;
  logic [CNT_W-1:0]      faults_r, faults_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lrupr_out_t            out_data_r, out_data_nxt;

  logic                  accept;
  logic                  apply;
  logic [CNT_W-1:0]      hits_inc, faults_inc;
  logic [IDX_W-1:0]      slot_sel;
  logic                  ev_valid;
  logic [63:0]           page_wide, ev_wide, slot_wide;
  logic [31:0]           cfg_wide;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN:  if (cnt_r == '0) state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy   = 1'b1;
    accept = 1'b0;
    apply  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_SCAN:  busy = 1'b1;
      ST_APPLY: apply = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign cfg_frames_nxt = cfg_valid ? cfg_data : cfg_frames_r;

  // Scan timer: counts down from the last cell index to zero during the scan
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = SCAN_LAST;
    end else if ((state_r == ST_SCAN) && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Access latch: page fitted to the stored width, frame count clamped
  assign page_wide = 64'(in_data.page);
  assign cfg_wide  = 32'(cfg_frames_r);

  always_comb begin
    page_nxt = page_r;
    last_nxt = last_r;
    n_nxt    = n_r;
    if (accept) begin
      page_nxt = page_wide[PAGE_BITS-1:0];
      last_nxt = in_data.last_access;
      if (cfg_wide == 32'd0) begin
        n_nxt = N_W'(1);
      end else if (cfg_wide > 32'(NUM_FRAMES)) begin
        n_nxt = N_W'(NUM_FRAMES);
      end else begin
        n_nxt = N_W'(cfg_wide);
      end
    end
  end

  // Slot choice: match, else first empty, else oldest
  always_comb begin
    if (flags_i.hit) begin
      slot_sel = hit_idx_i;
    end else if (flags_i.empty) begin
      slot_sel = empty_idx_i;
    end else begin
      slot_sel = best_idx_i;
    end
  end

  assign ev_valid  = !flags_i.hit && !flags_i.empty;
  assign ev_wide   = ev_valid ? 64'(best_page_i) : 64'd0;
  assign slot_wide = 64'(slot_sel);

  // Saturating counts
  assign hits_inc   = (flags_i.hit && (hits_r != CNT_MAX)) ? hits_r + 1'b1 : hits_r;
  assign faults_inc = (!flags_i.hit && (faults_r != CNT_MAX)) ? faults_r + 1'b1 : faults_r;

  always_comb begin
    hits_nxt      = hits_r;
    faults_nxt    = faults_r;
    out_valid_nxt = apply;
    out_data_nxt  = out_data_r;
    if (apply) begin
      out_data_nxt.hit           = flags_i.hit;
      out_data_nxt.slot          = slot_wide[SLOT_W-1:0];
      out_data_nxt.evicted_valid = ev_valid;
      out_data_nxt.evicted_page  = ev_wide[PAGE_W-1:0];
      out_data_nxt.hits_so_far   = hits_inc;
      out_data_nxt.faults_so_far = faults_inc;
      hits_nxt   = last_r ? '0 : hits_inc;
      faults_nxt = last_r ? '0 : faults_inc;
    end
  end

  // Cell update command
  always_comb begin
    upd_o.apply   = apply;
    upd_o.is_hit  = flags_i.hit;
    upd_o.age_all = !flags_i.hit;
    upd_o.clear   = last_r;
  end

  assign slot_o  = slot_sel;
  assign limit_o = hit_rank_i;
  assign page_o  = page_r;
  assign n_o     = n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      cfg_frames_r <= CFG_FRAMES_RESET;
      n_r          <= N_W'(1);
      last_r       <= 1'b0;
      hits_r       <= '0;
      faults_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cfg_frames_r <= cfg_frames_nxt;
      n_r          <= n_nxt;
      last_r       <= last_nxt;
      hits_r       <= hits_nxt;
      faults_r     <= faults_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/lrupr_chk.sv =====
// ----------------------------------------------------------------------------
// lrupr_chk: port-level checks for the LRU page replacement block
// Watches the access, result and busy behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module lrupr_chk (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   out_valid,
  input  lrupr_pkg::lrupr_out_t  out_data
);
  import lrupr_pkg::*;

  // An accepted access keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted access did not raise busy");

  // A result word is delivered only once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // One result word per access, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |-> !out_data.evicted_valid)
    else $error("eviction reported on a hit");

  // No eviction means a zero evicted page
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.evicted_valid) |-> (out_data.evicted_page == '0))
    else $error("evicted page not zero without an eviction");

endmodule

bind lru_page_replacement lrupr_chk u_lrupr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== tb/sv/tb_lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// tb_lru_page_replacement: self-checking bench for the LRU page frame set
// Drives page accesses on the start/busy port and keeps its own model of the
// frames, recency ranks and run counts. Each result word is checked field by
// field against the expected word. Directed runs cover fills, hits,
// evictions, frame-count extremes and count changes in mid-run. Random runs
// follow, drawing pages from small per-run pools so that hits and evictions
// are frequent.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
  import lrupr_pkg::*;

  localparam int NUM_FRAMES      = 16;
  localparam int RESULT_LATENCY  = NUM_FRAMES + 2;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_ACCESSES = 1100;
  localparam int MAX_REPORTS     = 10;
  localparam logic [PAGE_W-1:0] PAGE_MAX  = '1;
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [CFG_W-1:0]  CFG_MAX   = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  lrupr_in_t         in_data = '0;
  logic              out_valid;
  lrupr_out_t        out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  lru_page_replacement uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Frame set as the bench sees it
  logic [PAGE_W-1:0] resident_page [NUM_FRAMES];
  logic              resident_valid [NUM_FRAMES];
  logic [SLOT_W-1:0] age_rank [NUM_FRAMES];
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  fault_count;
  logic [CFG_W-1:0]  frame_limit;

  lrupr_out_t expected_results [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         idle_enable = 1'b1;

  // Frames taking part for a given register value
  function automatic int frames_for(logic [CFG_W-1:0] value);
    if (value == 0) return 1;
    if (value > NUM_FRAMES) return NUM_FRAMES;
    return int'(value);
  endfunction

  function automatic void clear_run();
    for (int j = 0; j < NUM_FRAMES; j++) begin
      resident_valid[j] = 1'b0;
      age_rank[j] = '0;
    end
    hit_count = '0;
    fault_count = '0;
  endfunction

  // Frame s becomes newest; active valid frames younger than limit get older
  function automatic void age_frames(int n, int s, int limit);
    for (int j = 0; j < n; j++) begin
      if (j != s && resident_valid[j] && age_rank[j] < limit &&
          age_rank[j] < NUM_FRAMES - 1)
        age_rank[j] = age_rank[j] + 1'b1;
    end
    age_rank[s] = '0;
  endfunction

  // Result word for one access; updates the frame set
  function automatic lrupr_out_t lookup_page(lrupr_in_t acc);
    lrupr_out_t r;
    int n;
    int s;
    int oldest;
    bit found;
    r = '0;
    n = frames_for(frame_limit);
    s = 0;
    found = 1'b0;
    for (int j = 0; j < n; j++) begin
      if (!found && resident_valid[j] && resident_page[j] == acc.page) begin
        found = 1'b1;
        s = j;
      end
    end
    if (found) begin
      age_frames(n, s, int'(age_rank[s]));
      if (hit_count != COUNT_MAX) hit_count++;
      r.hit = 1'b1;
    end else begin
      // Lowest empty frame first, else the oldest one (ties to lowest index)
      for (int j = 0; j < n; j++) begin
        if (!found && !resident_valid[j]) begin
          found = 1'b1;
          s = j;
        end
      end
      if (!found) begin
        oldest = 0;
        s = 0;
        for (int j = 0; j < n; j++) begin
          if (age_rank[j] > oldest) begin
            oldest = int'(age_rank[j]);
            s = j;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page = resident_page[s];
      end
      age_frames(n, s, NUM_FRAMES);
      resident_page[s] = acc.page;
      resident_valid[s] = 1'b1;
      if (fault_count != COUNT_MAX) fault_count++;
    end
    r.slot = s[SLOT_W-1:0];
    r.hits_so_far = hit_count;
    r.faults_so_far = fault_count;
    if (acc.last_access) clear_run();
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got)
      log_mismatch($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  task automatic check_result(lrupr_out_t got);
    lrupr_out_t want;
    if (expected_results.size() == 0) begin
      log_mismatch($sformatf("result word with no access pending: %h", got));
    end else begin
      want = expected_results.pop_front();
      compare_field("hit", CNT_W'(want.hit), CNT_W'(got.hit));
      compare_field("slot", CNT_W'(want.slot), CNT_W'(got.slot));
      compare_field("evicted_valid", CNT_W'(want.evicted_valid),
                    CNT_W'(got.evicted_valid));
      compare_field("evicted_page", CNT_W'(want.evicted_page),
                    CNT_W'(got.evicted_page));
      compare_field("hits_so_far", want.hits_so_far, got.hits_so_far);
      compare_field("faults_so_far", want.faults_so_far, got.faults_so_far);
    end
  endtask

  // Checks results, then predicts accepted accesses and tracks config writes
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_run();
      frame_limit = CFG_FRAMES_RESET;
    end else begin
      if (out_valid) check_result(out_data);
      if (start && !busy) expected_results.push_back(lookup_page(in_data));
      if (cfg_valid && cfg_ready) frame_limit = cfg_data;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lru_page_replacement: mismatch");
      $finish;
    end
  end

  // One access word; returns at the edge that takes it, start left high
  task automatic send_access(logic [PAGE_W-1:0] page, logic last);
    int gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 99) < 30)
      gap = int'($urandom_range(1, 2 * RESULT_LATENCY));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= {page, last};
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_frames(logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Reset count of 4: fill, hits, LRU eviction, end of run and reuse after clear
  task automatic test_fill_and_evict();
    send_access('0, 1'b0);
    send_access(PAGE_MAX, 1'b0);
    send_access(20'h5A5A5, 1'b0);
    send_access(20'hA5A5A, 1'b0);
    send_access(PAGE_MAX, 1'b0);
    send_access('0, 1'b0);
    send_access(20'h12345, 1'b0);
    send_access(20'hA5A5A, 1'b1);
    send_access(20'hA5A5A, 1'b0);
    drain();
  endtask

  // Zero count acts as one frame; counts above the array size are clipped
  task automatic test_frame_counts();
    write_frames('0);
    send_access(20'h00001, 1'b0);
    send_access(20'h00002, 1'b0);
    send_access(20'h00002, 1'b1);
    drain();
    write_frames(CFG_MAX);
    send_access(20'h00003, 1'b0);
    send_access(20'h80000, 1'b0);
    send_access(20'h00003, 1'b1);
    drain();
  endtask

  // Hidden frames keep their pages; a duplicate resolves to the lowest frame
  task automatic test_count_change_midrun();
    write_frames(5'd4);
    send_access(20'h00010, 1'b0);
    send_access(20'h00011, 1'b0);
    send_access(20'h00012, 1'b0);
    send_access(20'h00013, 1'b0);
    drain();
    write_frames(5'd2);
    send_access(20'h00013, 1'b0);
    drain();
    write_frames(5'd4);
    send_access(20'h00013, 1'b0);
    send_access(20'h00012, 1'b1);
    drain();
  endtask

  // Runs of pool-drawn pages; some runs end in a count change, not a clear.
  // Count saturation needs 2^32 - 1 accesses and is out of reach here.
  task automatic test_random_runs();
    logic [PAGE_W-1:0] pool [$];
    logic [CFG_W-1:0]  setting;
    logic [PAGE_W-1:0] page;
    int sent;
    int run_no;
    int run_len;
    int pool_size;
    bit close_run;
    bit last;
    sent = 0;
    run_no = 0;
    while (sent < RANDOM_ACCESSES) begin
      drain();
      case ($urandom_range(0, 5))
        0: setting = '0;
        1: setting = 5'd1;
        2: setting = CFG_W'(NUM_FRAMES);
        3: setting = CFG_MAX;
        4: setting = CFG_W'(NUM_FRAMES + 1);
        default: setting = CFG_W'($urandom_range(0, 31));
      endcase
      write_frames(setting);
      // One long run without sender gaps
      idle_enable = (run_no != 3);
      pool_size = frames_for(setting) + int'($urandom_range(0, 4));
      pool.delete();
      for (int j = 0; j < pool_size; j++) begin
        case ($urandom_range(0, 9))
          0: pool.push_back('0);
          1: pool.push_back(PAGE_MAX);
          default: pool.push_back(PAGE_W'($urandom));
        endcase
      end
      run_len = (run_no == 3) ? 80 : int'($urandom_range(10, 60));
      close_run = $urandom_range(0, 3) != 0;
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 99) < 85) page = pool[$urandom_range(0, pool_size - 1)];
        else page = PAGE_W'($urandom);
        last = ($urandom_range(0, 99) < 3) || (close_run && i == run_len - 1);
        send_access(page, last);
      end
      sent += run_len;
      run_no++;
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_and_evict();
    test_frame_counts();
    test_count_change_midrun();
    test_random_runs();
    drain();
    repeat (RESULT_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("lru_page_replacement: match");
    end else begin
      $display("lru_page_replacement: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lrupr_pkg.sv
design/lrupr_cell.sv
design/lrupr_ctrl.sv
design/lru_page_replacement.sv
design/lrupr_chk.sv
tb/sv/tb_lru_page_replacement.sv
